### rtl/pcsa_pkg.sv
// Package for the PCI configuration space access block.
// Holds table sizing, op and status codes, offsets and the table port structs.
// No dependencies.
package pcsa_pkg;

  localparam int MAX_DEVICES = 64;
  localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W       = $clog2(MAX_DEVICES + 1);
  localparam int AIDX_W      = 6;
  localparam int LOOK_W      = 13;  // bus (8) and slot (5)
  localparam int META_W      = 20;

  localparam logic [7:0]  VENDOR_OFFSET = 8'd0;
  localparam logic [7:0]  CLASS_OFFSET  = 8'd8;
  localparam logic [7:0]  SUBSYS_OFFSET = 8'd44;
  localparam logic [7:0]  OFFSET_MASK   = 8'hFC;
  localparam logic [31:0] MISS_DATA     = 32'h0000_FFFF;
  localparam int          META_RETIRED  = 19;

  typedef enum logic [1:0] {
    OP_ADDR  = 2'd0,
    OP_READ  = 2'd1,
    OP_REG   = 2'd2,
    OP_DEREG = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Write side of the device table.
  typedef struct packed {
    logic              meta_we;
    logic              words_we;
    logic [IDX_W-1:0]  idx;
    logic [META_W-1:0] meta;
    logic [31:0]       vendor_word;
    logic [31:0]       subsys_word;
  } tbl_wr_t;

  // Registered read side of the device table.
  typedef struct packed {
    logic [META_W-1:0] meta;
    logic [31:0]       vendor_word;
    logic [31:0]       subsys_word;
  } tbl_rd_t;

endpackage

### rtl/pcsa_table.sv
// Device table: metadata, vendor word and subsystem word per entry.
// One write port, one read port with registered data. Uses pcsa_pkg.
module pcsa_table (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [pcsa_pkg::IDX_W-1:0]   rd_idx,
  output pcsa_pkg::tbl_rd_t            rd_data,
  input  pcsa_pkg::tbl_wr_t            wr
);

  logic [pcsa_pkg::META_W-1:0] meta_mem   [pcsa_pkg::MAX_DEVICES];
  logic [31:0]                 vendor_mem [pcsa_pkg::MAX_DEVICES];
  logic [31:0]                 subsys_mem [pcsa_pkg::MAX_DEVICES];

  pcsa_pkg::tbl_rd_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.meta_we) begin
      meta_mem[wr.idx] <= wr.meta;
    end
    if (wr.words_we) begin
      vendor_mem[wr.idx] <= wr.vendor_word;
      subsys_mem[wr.idx] <= wr.subsys_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.meta        <= meta_mem[rd_idx];
      rd_data_r.vendor_word <= vendor_mem[rd_idx];
      rd_data_r.subsys_word <= subsys_mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/pci_config_space_access.sv
// Top level of the PCI configuration space access block (mechanism 1).
// Address latch, entry count, sequencer and result register; uses pcsa_pkg
// and the device table in pcsa_table.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid/in_ready   | op, port data, device fields
//   out_    | output    | out_valid/out_ready | read_data, status, assigned_index
//
// The accepting edge issues the table read and the item waits in evaluation;
// the edge on which the result register is free evaluates the registered read
// data, writes the table back and loads the result register.
// Reset clears the address latch, entry count and sequencer; the table needs
// no clearing, only entries below the count are ever looked up.
// While a result waits to be taken, the next item is accepted and held in
// evaluation until the result register frees up.
module pci_config_space_access (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_port_data,
  input  logic [7:0]  in_bus,
  input  logic [4:0]  in_slot,
  input  logic [2:0]  in_function_req,
  input  logic [7:0]  in_class_code,
  input  logic [7:0]  in_subclass,
  input  logic [15:0] in_vendor_id,
  input  logic [15:0] in_device_id,
  input  logic [15:0] in_sub_vendor_id,
  input  logic [15:0] in_sub_device_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_status,
  output logic [5:0]  out_assigned_index
);

  pcsa_pkg::state_t state_r, state_nxt;

  // Captured item
  pcsa_pkg::op_t              op_r;
  logic [31:0]                data_r;
  logic [2:0]                 func_r;
  logic [7:0]                 cls_r, sub_r;
  logic [15:0]                vend_r, dev_r, svend_r, sdev_r;
  logic                       idx_ok_r;
  logic [pcsa_pkg::IDX_W-1:0] idx_r;

  logic [30:0]                latch_r, latch_nxt;
  logic [pcsa_pkg::CNT_W-1:0] count_r, count_nxt;

  logic                          out_valid_r;
  logic [31:0]                   out_read_data_r, rd_nxt;
  pcsa_pkg::status_t             out_status_r, status_nxt;
  logic [pcsa_pkg::AIDX_W-1:0]   out_assigned_index_r, aidx_nxt;

  logic                        accept, fire, live, full;
  logic [pcsa_pkg::LOOK_W-1:0] look;
  logic [2:0]                  cmp_func;
  logic [7:0]                  offset;
  pcsa_pkg::tbl_rd_t           rd;
  pcsa_pkg::tbl_wr_t           wr;

  assign accept = in_valid && in_ready;

  // Lookup index from the latch for a data read, from the item for a retire.
  always_comb begin
    if (pcsa_pkg::op_t'(in_op) == pcsa_pkg::OP_READ) begin
      look = {latch_r[23:16], latch_r[15:11]};
    end else begin
      look = {in_bus, in_slot};
    end
  end

  pcsa_table u_table (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (look[pcsa_pkg::IDX_W-1:0]),
    .rd_data (rd),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= pcsa_pkg::op_t'(in_op);
      data_r   <= in_port_data;
      func_r   <= in_function_req;
      cls_r    <= in_class_code;
      sub_r    <= in_subclass;
      vend_r   <= in_vendor_id;
      dev_r    <= in_device_id;
      svend_r  <= in_sub_vendor_id;
      sdev_r   <= in_sub_device_id;
      idx_ok_r <= look < pcsa_pkg::LOOK_W'(count_r);
      idx_r    <= look[pcsa_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcsa_pkg::S_IDLE;
      latch_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      latch_r <= latch_nxt;
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_data_r      <= rd_nxt;
      out_status_r         <= status_nxt;
      out_assigned_index_r <= aidx_nxt;
    end
  end

  assign cmp_func = (op_r == pcsa_pkg::OP_READ) ? latch_r[10:8] : func_r;
  assign offset   = latch_r[7:0] & pcsa_pkg::OFFSET_MASK;
  assign live     = idx_ok_r && !rd.meta[pcsa_pkg::META_RETIRED]
                    && (rd.meta[18:16] == cmp_func);
  assign full     = count_r >= pcsa_pkg::CNT_W'(pcsa_pkg::MAX_DEVICES);

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    fire       = 1'b0;
    latch_nxt  = latch_r;
    count_nxt  = count_r;
    rd_nxt     = '0;
    status_nxt = pcsa_pkg::ST_OK;
    aidx_nxt   = '0;
    wr         = '0;
    wr.idx     = idx_r;
    unique case (state_r)
      pcsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = pcsa_pkg::S_EXEC;
        end
      end
      pcsa_pkg::S_EXEC: begin
        fire = !out_valid_r || out_ready;
        unique case (op_r)
          pcsa_pkg::OP_ADDR: begin
            if (data_r[31]) begin
              latch_nxt = fire ? data_r[30:0] : latch_r;
            end
          end
          pcsa_pkg::OP_READ: begin
            if (!live) begin
              rd_nxt     = pcsa_pkg::MISS_DATA;
              status_nxt = pcsa_pkg::ST_MISS;
            end else if (offset == pcsa_pkg::SUBSYS_OFFSET) begin
              rd_nxt = rd.subsys_word;
            end else if (offset == pcsa_pkg::VENDOR_OFFSET) begin
              rd_nxt = rd.vendor_word;
            end else if (offset == pcsa_pkg::CLASS_OFFSET) begin
              rd_nxt = {rd.meta[15:0], 16'h0000};
            end
          end
          pcsa_pkg::OP_REG: begin
            if (full) begin
              status_nxt = pcsa_pkg::ST_FULL;
            end else begin
              aidx_nxt       = pcsa_pkg::AIDX_W'(count_r);
              wr.idx         = count_r[pcsa_pkg::IDX_W-1:0];
              wr.meta        = {1'b0, func_r, cls_r, sub_r};
              wr.vendor_word = {dev_r, vend_r};
              wr.subsys_word = {sdev_r, svend_r};
              wr.meta_we     = fire;
              wr.words_we    = fire;
              if (fire) begin
                count_nxt = count_r + 1'b1;
              end
            end
          end
          pcsa_pkg::OP_DEREG: begin
            if (!live) begin
              status_nxt = pcsa_pkg::ST_MISS;
            end else begin
              // Retire the entry for good; its index stays allocated.
              wr.meta    = rd.meta | (pcsa_pkg::META_W'(1) << pcsa_pkg::META_RETIRED);
              wr.meta_we = fire;
            end
          end
          default: begin
          end
        endcase
        if (fire) begin
          state_nxt = pcsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pcsa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_status         = out_status_r;
  assign out_assigned_index = out_assigned_index_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pcsa_pkg::CNT_W'(pcsa_pkg::MAX_DEVICES))
    else $error("entry count beyond table size");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == pcsa_pkg::S_EXEC)
    else $error("accepted item not evaluated");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcsa_pkg::S_EXEC && out_valid_r && !out_ready)
      |=> (state_r == pcsa_pkg::S_EXEC && $stable(count_r) && $stable(latch_r)))
    else $error("item left evaluation while result register busy");

  a_reg_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op_r == pcsa_pkg::OP_REG && !full)
      |=> count_r == $past(count_r) + 1'b1)
    else $error("register did not advance entry count");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == pcsa_pkg::ST_FULL) |-> out_assigned_index_r == '0)
    else $error("table full result carries an index");

endmodule

### tb/sv/pcsa_reply_check.sv
`timescale 1ns / 1ps
// Result checker for pci_config_space_access: models the address latch and the
// device table, predicts one reply per accepted item and compares in order.
// Depends on pcsa_pkg for op and status codes, table size and offsets.
module pcsa_reply_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_port_data,
  input  logic [7:0]  in_bus,
  input  logic [4:0]  in_slot,
  input  logic [2:0]  in_function_req,
  input  logic [7:0]  in_class_code,
  input  logic [7:0]  in_subclass,
  input  logic [15:0] in_vendor_id,
  input  logic [15:0] in_device_id,
  input  logic [15:0] in_sub_vendor_id,
  input  logic [15:0] in_sub_device_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_read_data,
  input  logic [1:0]  out_status,
  input  logic [5:0]  out_assigned_index,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0]       read_data;
    pcsa_pkg::status_t status;
    logic [5:0]        index;
  } cfg_reply_t;

  logic [30:0]                 addr_latch;
  int                          dev_count;
  logic [pcsa_pkg::META_W-1:0] dev_meta   [pcsa_pkg::MAX_DEVICES];
  logic [31:0]                 dev_vendor [pcsa_pkg::MAX_DEVICES];
  logic [31:0]                 dev_subsys [pcsa_pkg::MAX_DEVICES];
  cfg_reply_t                  reply_q[$];

  // Index of a live entry at bus/slot carrying the function, else -1.
  function automatic int find_live(logic [7:0] bus, logic [4:0] slot, logic [2:0] fn);
    int idx;
    idx = int'(bus) * 32 + int'(slot);
    if (idx >= dev_count || idx >= pcsa_pkg::MAX_DEVICES) return -1;
    if (dev_meta[idx][pcsa_pkg::META_RETIRED]) return -1;
    if (dev_meta[idx][18:16] != fn) return -1;
    return idx;
  endfunction

  function automatic cfg_reply_t config_access(pcsa_pkg::op_t op);
    cfg_reply_t r;
    int         hit;
    logic [7:0] offset;
    r = '{read_data: '0, status: pcsa_pkg::ST_OK, index: '0};
    case (op)
      pcsa_pkg::OP_ADDR: begin
        if (in_port_data[31]) addr_latch = in_port_data[30:0];
      end
      pcsa_pkg::OP_READ: begin
        offset = addr_latch[7:0] & pcsa_pkg::OFFSET_MASK;
        hit = find_live(addr_latch[23:16], addr_latch[15:11], addr_latch[10:8]);
        if (hit < 0) begin
          r.read_data = pcsa_pkg::MISS_DATA;
          r.status    = pcsa_pkg::ST_MISS;
        end else if (offset == pcsa_pkg::SUBSYS_OFFSET) begin
          r.read_data = dev_subsys[hit];
        end else if (offset == pcsa_pkg::VENDOR_OFFSET) begin
          r.read_data = dev_vendor[hit];
        end else if (offset == pcsa_pkg::CLASS_OFFSET) begin
          r.read_data = {dev_meta[hit][15:0], 16'h0000};
        end
      end
      pcsa_pkg::OP_REG: begin
        if (dev_count >= pcsa_pkg::MAX_DEVICES) begin
          r.status = pcsa_pkg::ST_FULL;
        end else begin
          dev_meta[dev_count]   = {1'b0, in_function_req, in_class_code, in_subclass};
          dev_vendor[dev_count] = {in_device_id, in_vendor_id};
          dev_subsys[dev_count] = {in_sub_device_id, in_sub_vendor_id};
          r.index   = 6'(dev_count);
          dev_count = dev_count + 1;
        end
      end
      default: begin
        hit = find_live(in_bus, in_slot, in_function_req);
        if (hit < 0) r.status = pcsa_pkg::ST_MISS;
        else dev_meta[hit][pcsa_pkg::META_RETIRED] = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cfg_reply_t want;
    if (!rst_n) begin
      addr_latch = '0;
      dev_count  = 0;
      reply_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h/%0d/%0d", $time,
                   out_read_data, out_status, out_assigned_index);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, out_read_data);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_status);
            fail_count++;
          end
          if (out_assigned_index !== want.index) begin
            $display("%0t: assigned_index expected %0d actual %0d", $time,
                     want.index, out_assigned_index);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) reply_q.push_back(config_access(pcsa_pkg::op_t'(in_op)));
    end
    outstanding = reply_q.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for pci_config_space_access: clock, reset, item stimulus with
// bursty valid and a patterned out_ready; checking lives in pcsa_reply_check.
// Depends on pcsa_pkg, the block and pcsa_reply_check.
module tb_top;

  typedef struct {
    pcsa_pkg::op_t op;
    logic [31:0]   port_data;
    logic [7:0]    bus;
    logic [4:0]    slot;
    logic [2:0]    fn;
    logic [7:0]    class_code;
    logic [7:0]    subclass;
    logic [15:0]   vendor_id;
    logic [15:0]   device_id;
    logic [15:0]   sub_vendor_id;
    logic [15:0]   sub_device_id;
  } cfg_item_t;

  localparam int RANDOM_ITEMS = 1550;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [31:0] in_port_data;
  logic [7:0]  in_bus;
  logic [4:0]  in_slot;
  logic [2:0]  in_function_req;
  logic [7:0]  in_class_code;
  logic [7:0]  in_subclass;
  logic [15:0] in_vendor_id;
  logic [15:0] in_device_id;
  logic [15:0] in_sub_vendor_id;
  logic [15:0] in_sub_device_id;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;
  logic [1:0]  out_status;
  logic [5:0]  out_assigned_index;
  int          fail_count;
  int          outstanding;

  int          items_sent;
  int          burst_left;
  int          devs_issued;
  logic [2:0]  dev_fn [pcsa_pkg::MAX_DEVICES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pci_config_space_access dut (.*);

  pcsa_reply_check u_check (.*);

  // Receiver: free-flowing, coin-toss and mostly-stalled stretches.
  always @(negedge clk) begin
    int mode;
    int mode_left;
    if (mode_left == 0) begin
      mode      = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 150);
    end
    mode_left--;
    case (mode)
      0:       out_ready = 1'b1;
      1:       out_ready = 1'($urandom);
      default: out_ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic cfg_item_t noise_item();
    cfg_item_t it;
    it.op            = pcsa_pkg::op_t'($urandom_range(0, 3));
    it.port_data     = $urandom;
    it.bus           = 8'($urandom);
    it.slot          = 5'($urandom);
    it.fn            = 3'($urandom);
    it.class_code    = 8'($urandom);
    it.subclass      = 8'($urandom);
    it.vendor_id     = 16'($urandom);
    it.device_id     = 16'($urandom);
    it.sub_vendor_id = 16'($urandom);
    it.sub_device_id = 16'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] addr_word(logic en, logic [7:0] bus, logic [4:0] slot,
                                            logic [2:0] fn, logic [7:0] offset);
    return {en, 7'($urandom), bus, slot, fn, offset};
  endfunction

  function automatic logic [7:0] pick_offset();
    logic [7:0] base;
    case ($urandom_range(0, 4))
      0:       base = pcsa_pkg::VENDOR_OFFSET;
      1:       base = pcsa_pkg::CLASS_OFFSET;
      2:       base = pcsa_pkg::SUBSYS_OFFSET;
      default: base = 8'($urandom);
    endcase
    return (base & pcsa_pkg::OFFSET_MASK) | 8'($urandom_range(0, 3));
  endfunction

  // Present one item and hold it until accepted.
  task automatic drive_item(cfg_item_t it);
    @(negedge clk);
    in_op            = it.op;
    in_port_data     = it.port_data;
    in_bus           = it.bus;
    in_slot          = it.slot;
    in_function_req  = it.fn;
    in_class_code    = it.class_code;
    in_subclass      = it.subclass;
    in_vendor_id     = it.vendor_id;
    in_device_id     = it.device_id;
    in_sub_vendor_id = it.sub_vendor_id;
    in_sub_device_id = it.sub_device_id;
    in_valid         = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send in bursts; between bursts drop valid for a random gap.
  task automatic issue_item(cfg_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    if (it.op == pcsa_pkg::OP_REG) begin
      if (devs_issued < pcsa_pkg::MAX_DEVICES) dev_fn[devs_issued] = it.fn;
      devs_issued++;
    end
    drive_item(it);
    items_sent++;
  endtask

  task automatic register_dev(logic [2:0] fn);
    cfg_item_t it;
    it    = noise_item();
    it.op = pcsa_pkg::OP_REG;
    it.fn = fn;
    issue_item(it);
  endtask

  task automatic write_addr(logic [31:0] word);
    cfg_item_t it;
    it           = noise_item();
    it.op        = pcsa_pkg::OP_ADDR;
    it.port_data = word;
    issue_item(it);
  endtask

  task automatic read_data_port();
    cfg_item_t it;
    it    = noise_item();
    it.op = pcsa_pkg::OP_READ;
    issue_item(it);
  endtask

  task automatic deregister(logic [7:0] bus, logic [4:0] slot, logic [2:0] fn);
    cfg_item_t it;
    it      = noise_item();
    it.op   = pcsa_pkg::OP_DEREG;
    it.bus  = bus;
    it.slot = slot;
    it.fn   = fn;
    issue_item(it);
  endtask

  // Pick a table index near the appended range, and a function that mostly fits.
  task automatic pick_target(output int idx, output logic [2:0] fn);
    int live;
    live = (devs_issued < pcsa_pkg::MAX_DEVICES) ? devs_issued : pcsa_pkg::MAX_DEVICES;
    if (live == 0 || $urandom_range(0, 9) == 0) idx = $urandom_range(0, live + 1);
    else idx = $urandom_range(0, live - 1);
    if (idx < live && $urandom_range(0, 5) != 0) fn = dev_fn[idx];
    else fn = 3'($urandom);
  endtask

  initial begin
    cfg_item_t  it;
    int         idx;
    int         pick;
    logic [2:0] fn;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = pcsa_pkg::OP_ADDR;
    in_port_data     = '0;
    in_bus           = '0;
    in_slot          = '0;
    in_function_req  = '0;
    in_class_code    = '0;
    in_subclass      = '0;
    in_vendor_id     = '0;
    in_device_id     = '0;
    in_sub_vendor_id = '0;
    in_sub_device_id = '0;
    items_sent       = 0;
    burst_left       = 0;
    devs_issued      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-table read, extreme registrations, every offset, misses.
    read_data_port();
    it = noise_item();
    it.op = pcsa_pkg::OP_REG; it.fn = 3'h7; it.class_code = 8'hFF; it.subclass = 8'hFF;
    it.vendor_id = 16'hFFFF; it.device_id = 16'hFFFF;
    it.sub_vendor_id = 16'hFFFF; it.sub_device_id = 16'hFFFF;
    issue_item(it);
    it = noise_item();
    it.op = pcsa_pkg::OP_REG; it.fn = 3'h0; it.class_code = 8'h00; it.subclass = 8'h00;
    it.vendor_id = 16'h0000; it.device_id = 16'h0000;
    it.sub_vendor_id = 16'h0000; it.sub_device_id = 16'h0000;
    issue_item(it);
    write_addr(32'h8000_0700);
    read_data_port();
    write_addr(32'h8000_0708);
    read_data_port();
    write_addr(32'h8000_072F);
    read_data_port();
    write_addr(32'h8000_0704);
    read_data_port();
    // Without bit 31 the latch holds.
    write_addr(32'h7FFF_FFFF);
    read_data_port();
    write_addr(32'h8000_0000);
    read_data_port();
    write_addr(32'hFFFF_FFFF);
    read_data_port();
    deregister(8'h00, 5'h00, 3'h7);
    deregister(8'h00, 5'h00, 3'h7);
    write_addr(32'h8000_0700);
    read_data_port();
    deregister(8'hFF, 5'h1F, 3'h7);
    write_addr(32'h8000_082C);
    read_data_port();

    // Random: mostly address-then-read sequences against appended entries.
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pick_target(idx, fn);
        write_addr(addr_word(1'b1, 8'(idx >> 5), 5'(idx), fn, pick_offset()));
        repeat ($urandom_range(1, 2)) read_data_port();
      end else if (pick < 53) begin
        register_dev(3'($urandom));
      end else if (pick < 63) begin
        pick_target(idx, fn);
        if ($urandom_range(0, 3) == 0) deregister(8'($urandom), 5'($urandom), 3'($urandom));
        else deregister(8'(idx >> 5), 5'(idx), fn);
      end else if (pick < 78) begin
        write_addr($urandom);
      end else if (pick < 93) begin
        read_data_port();
      end else begin
        pick_target(idx, fn);
        write_addr(addr_word(1'b0, 8'(idx >> 5), 5'(idx), fn, pick_offset()));
        read_data_port();
      end
    end

    // Fill the table, then run into the full case and read the last entry and the index past it.
    while (devs_issued < pcsa_pkg::MAX_DEVICES + 2) register_dev(3'($urandom));
    write_addr(addr_word(1'b1, 8'((pcsa_pkg::MAX_DEVICES - 1) >> 5),
                         5'(pcsa_pkg::MAX_DEVICES - 1),
                         dev_fn[pcsa_pkg::MAX_DEVICES - 1], pcsa_pkg::VENDOR_OFFSET));
    read_data_port();
    write_addr(addr_word(1'b1, 8'(pcsa_pkg::MAX_DEVICES >> 5), 5'(pcsa_pkg::MAX_DEVICES),
                         3'($urandom), pcsa_pkg::VENDOR_OFFSET));
    read_data_port();

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/pcsa_pkg.sv
rtl/pcsa_table.sv
rtl/pci_config_space_access.sv
tb/sv/pcsa_reply_check.sv
tb/sv/tb_top.sv
